FILE: sv/mkced_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mkced_pkg: shared types and constants of the click event detector
// Register indexes, flag bit positions, press phase codes and the
// control and timer structs passed from the top level to the key cells.
// ----------------------------------------------------------------------------
package mkced_pkg;

   // field widths
   localparam int SCAN_W  = 8;
   localparam int TICKS_W = 16;
   localparam int MASK_W  = 4;
   localparam int FLAG_W  = 7;
   localparam int IDX_W   = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   // keys that have a pin in the pin field
   localparam int PIN_FIELD_KEYS = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_PERIOD  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_TICKS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DOUBLE_TICKS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_TICKS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_MASK  = 3'd4;

   // register reset values
   localparam logic [SCAN_W-1:0]  RST_SCAN_PERIOD  = 8'd15;
   localparam logic [TICKS_W-1:0] RST_LONG_TICKS   = 16'd2000;
   localparam logic [TICKS_W-1:0] RST_DOUBLE_TICKS = 16'd200;
   localparam logic [TICKS_W-1:0] RST_REPEAT_TICKS = 16'd100;
   localparam logic [MASK_W-1:0]  RST_ACTIVE_MASK  = 4'd12;

   // event flag bit positions
   localparam int FLAG_HOLD   = 0;
   localparam int FLAG_DOWN   = 1;
   localparam int FLAG_UP     = 2;
   localparam int FLAG_SINGLE = 3;
   localparam int FLAG_DOUBLE = 4;
   localparam int FLAG_LONG   = 5;
   localparam int FLAG_REPEAT = 6;

   // per-key press phase
   typedef enum logic [2:0] {
      PH_IDLE        = 3'd0,
      PH_PRESSED     = 3'd1,
      PH_WAIT_SECOND = 3'd2,
      PH_SECOND_HELD = 3'd3,
      PH_LONG_HELD   = 3'd4
   } phase_type;

   // timer reload values
   typedef struct packed {
      logic [TICKS_W-1:0] long_ticks;
      logic [TICKS_W-1:0] double_ticks;
      logic [TICKS_W-1:0] repeat_ticks;
   } timer_cfg_type;

   // what the current word does to the key cells
   typedef struct packed {
      logic              tick;
      logic              scan;
      logic              check;
      logic [IDX_W-1:0]  key_index;
      logic [FLAG_W-1:0] event_mask;
   } step_ctrl_type;

endpackage
`default_nettype wire

FILE: sv/mkced_key.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mkced_key: state of one key
// Countdown timer, debounced level, press phase and sticky event flags,
// updated by ticks and scans, read and cleared by checks.
// ----------------------------------------------------------------------------
module mkced_key
   import mkced_pkg::*;
#(
   parameter int KEY_ID     = 0,
   parameter int TIMER_BITS = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire step_ctrl_type ctrl,
   input  wire timer_cfg_type tcfg,
   input  wire logic          sample,
   output logic               hit
);

   logic [TIMER_BITS-1:0] countdown_ff, countdown_in;
   logic                  pressed_ff, pressed_in;
   phase_type             phase_ff, phase_in;
   logic [FLAG_W-1:0]     flags_ff, flags_in;

   logic                  selected;
   logic [TIMER_BITS-1:0] load_long, load_double, load_repeat;

   assign selected    = ctrl.check && (32'(ctrl.key_index) == KEY_ID);
   assign load_long   = TIMER_BITS'(tcfg.long_ticks);
   assign load_double = TIMER_BITS'(tcfg.double_ticks);
   assign load_repeat = TIMER_BITS'(tcfg.repeat_ticks);

   // next state of the key
   always_comb begin
      countdown_in = countdown_ff;
      pressed_in   = pressed_ff;
      phase_in     = phase_ff;
      flags_in     = flags_ff;
      hit          = 1'b0;

      // countdown runs on every tick, ahead of the scan
      if (ctrl.tick && (countdown_ff != '0)) begin
         countdown_in = countdown_ff - 1'b1;
      end

      if (ctrl.scan) begin
         pressed_in = sample;
         flags_in[FLAG_HOLD] = sample;
         if (sample && !pressed_ff) begin
            flags_in[FLAG_DOWN] = 1'b1;
         end
         if (!sample && pressed_ff) begin
            flags_in[FLAG_UP] = 1'b1;
         end

         // press phase machine
         case (phase_ff)
            PH_PRESSED: begin
               if (!sample) begin
                  countdown_in = load_double;
                  phase_in     = PH_WAIT_SECOND;
               end else if (countdown_in == '0) begin
                  countdown_in        = load_repeat;
                  flags_in[FLAG_LONG] = 1'b1;
                  phase_in            = PH_LONG_HELD;
               end
            end
            PH_WAIT_SECOND: begin
               if (sample) begin
                  flags_in[FLAG_DOUBLE] = 1'b1;
                  phase_in              = PH_SECOND_HELD;
               end else if (countdown_in == '0) begin
                  flags_in[FLAG_SINGLE] = 1'b1;
                  phase_in              = PH_IDLE;
               end
            end
            PH_SECOND_HELD: begin
               if (!sample) begin
                  phase_in = PH_IDLE;
               end
            end
            PH_LONG_HELD: begin
               if (!sample) begin
                  phase_in = PH_IDLE;
               end else if (countdown_in == '0) begin
                  countdown_in          = load_repeat;
                  flags_in[FLAG_REPEAT] = 1'b1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               if (sample) begin
                  countdown_in = load_long;
                  phase_in     = PH_PRESSED;
               end
            end
         endcase
      end

      // check: report and clear masked flags, hold stays
      if (selected && ((flags_ff & ctrl.event_mask) != '0)) begin
         hit = 1'b1;
         flags_in = flags_ff &
                    ~(ctrl.event_mask & ~(FLAG_W'(1) << FLAG_HOLD));
      end
   end

   // key state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff <= '0;
         pressed_ff   <= 1'b0;
         phase_ff     <= PH_IDLE;
         flags_ff     <= '0;
      end else begin
         countdown_ff <= countdown_in;
         pressed_ff   <= pressed_in;
         phase_ff     <= phase_in;
         flags_ff     <= flags_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/multi_key_click_event_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_key_click_event_detector: per-key click event detector
// Debounced scan of the key pins with single, double, long and repeat
// press flags, read and cleared by check words.
// ----------------------------------------------------------------------------
// Takes one word per cycle on req and gives one word per cycle on rsp while
// rsp_tready stays high; a word is held in the input register, is applied to
// the key cells and lands in the result register, which drives rsp_tvalid.
// While a result waits for rsp_tready, the input register takes one more
// word and then req_tready drops until the result is taken. A tick word
// (tuser 0) decrements all nonzero key timers and, every scan_period ticks,
// samples the pins; its result is hit 0. A check word (tuser 1) returns hit
// 1 if any flag of the chosen key under the mask is set, and clears those
// flags except hold. Write registers only while idle.
// ----------------------------------------------------------------------------
module multi_key_click_event_detector
   import mkced_pkg::*;
#(
   parameter int KEYS       = 4,
   parameter int TIMER_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input words
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [15:0]           req_tdata,  // pin_levels[3:0], key_index[5:4],
                                                  // event_mask[12:6], zero pad
   input  wire logic                  req_tuser,  // kind
   // result words
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [7:0]                 rsp_tdata,  // hit[0], zero pad
   // register writes
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration registers
   logic [SCAN_W-1:0]  scan_period_ff;
   logic [TICKS_W-1:0] long_ticks_ff, double_ticks_ff, repeat_ticks_ff;
   logic [MASK_W-1:0]  active_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_period_ff  <= RST_SCAN_PERIOD;
         long_ticks_ff   <= RST_LONG_TICKS;
         double_ticks_ff <= RST_DOUBLE_TICKS;
         repeat_ticks_ff <= RST_REPEAT_TICKS;
         active_mask_ff  <= RST_ACTIVE_MASK;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SCAN_PERIOD:  scan_period_ff  <= csr_wdata[SCAN_W-1:0];
            CSR_LONG_TICKS:   long_ticks_ff   <= csr_wdata[TICKS_W-1:0];
            CSR_DOUBLE_TICKS: double_ticks_ff <= csr_wdata[TICKS_W-1:0];
            CSR_REPEAT_TICKS: repeat_ticks_ff <= csr_wdata[TICKS_W-1:0];
            CSR_ACTIVE_MASK:  active_mask_ff  <= csr_wdata[MASK_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   logic               s1_valid_ff;
   logic               s1_kind_ff;
   logic [3:0]         s1_pins_ff;
   logic [IDX_W-1:0]   s1_idx_ff;
   logic [FLAG_W-1:0]  s1_mask_ff;
   logic               advance;

   assign advance    = s1_valid_ff && (!rsp_tvalid || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_kind_ff <= req_tuser;
         s1_pins_ff <= req_tdata[3:0];
         s1_idx_ff  <= req_tdata[5:4];
         s1_mask_ff <= req_tdata[12:6];
      end
   end

   // scan divider
   logic [SCAN_W-1:0] scan_count_ff, scan_count_in, scan_count_inc;
   logic              tick, scan;

   assign tick           = advance && !s1_kind_ff;
   assign scan_count_inc = scan_count_ff + 1'b1;
   assign scan           = tick && (scan_count_inc >= scan_period_ff);

   always_comb begin
      scan_count_in = scan_count_ff;
      if (scan) begin
         scan_count_in = '0;
      end else if (tick) begin
         scan_count_in = scan_count_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_count_ff <= '0;
      end else begin
         scan_count_ff <= scan_count_in;
      end
   end

   // control to the key cells
   step_ctrl_type ctrl;
   timer_cfg_type tcfg;

   assign ctrl.tick       = tick;
   assign ctrl.scan       = scan;
   assign ctrl.check      = advance && s1_kind_ff;
   assign ctrl.key_index  = s1_idx_ff;
   assign ctrl.event_mask = s1_mask_ff;

   assign tcfg.long_ticks   = long_ticks_ff;
   assign tcfg.double_ticks = double_ticks_ff;
   assign tcfg.repeat_ticks = repeat_ticks_ff;

   // key cells
   logic [KEYS-1:0] key_hit;
   logic [KEYS-1:0] key_sample;

   for (genvar k = 0; k < KEYS; k++) begin : g_key
      if (k < PIN_FIELD_KEYS) begin : g_pin
         assign key_sample[k] = (s1_pins_ff[k] == active_mask_ff[k]);
      end else begin : g_nopin
         assign key_sample[k] = 1'b0;
      end

      mkced_key #(
         .KEY_ID     (k),
         .TIMER_BITS (TIMER_BITS)
      ) u_key (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (ctrl),
         .tcfg   (tcfg),
         .sample (key_sample[k]),
         .hit    (key_hit[k])
      );
   end

   // result register
   logic rsp_valid_ff;
   logic rsp_hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hit_ff <= |key_hit;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_hit_ff};

endmodule
`default_nettype wire

FILE: sim/tb_multi_key_click_event_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_key_click_event_detector: self-checking bench of the click detector
// Streams tick and check words into the detector under several register
// settings, predicts every hit result with an in-bench model of the four
// key press machines, and compares each result word in order of arrival.
// ----------------------------------------------------------------------------
module tb_multi_key_click_event_detector
   import mkced_pkg::*;
;

   localparam int NUM_KEYS        = 4;
   localparam int HOLD_OFF_CYCLES = 120;
   localparam int DRAIN_LIMIT     = 5000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int RUN_LIMIT_NS    = 4_000_000;
   localparam int PHASE_WORDS     = 255;
   localparam int REPORT_CAP      = 200;

   // register indexes that map to no register
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_FIRST = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LAST  = 3'd7;

   // word kinds on req_tuser
   localparam bit KIND_TICK  = 1'b0;
   localparam bit KIND_CHECK = 1'b1;

   typedef enum {CHK_OK, CHK_MISMATCH, CHK_UNEXPECTED} check_status_type;
   typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   // ------------------------------------------------------------------------
   // press machine model and store of expected hits
   // ------------------------------------------------------------------------
   class click_scoreboard;
      bit [SCAN_W-1:0]  scan_period;
      bit [TICKS_W-1:0] long_ticks;
      bit [TICKS_W-1:0] double_ticks;
      bit [TICKS_W-1:0] repeat_ticks;
      bit [MASK_W-1:0]  active_mask;
      bit [SCAN_W-1:0]  scan_count;
      bit               pressed[NUM_KEYS];
      bit               pressed_prev[NUM_KEYS];
      phase_type        phase[NUM_KEYS];
      bit [TICKS_W-1:0] countdown[NUM_KEYS];
      bit [FLAG_W-1:0]  flags[NUM_KEYS];
      bit               expected_hits[$];

      function new();
         scan_period  = RST_SCAN_PERIOD;
         long_ticks   = RST_LONG_TICKS;
         double_ticks = RST_DOUBLE_TICKS;
         repeat_ticks = RST_REPEAT_TICKS;
         active_mask  = RST_ACTIVE_MASK;
         scan_count   = '0;
         for (int k = 0; k < NUM_KEYS; k++) begin
            pressed[k]      = 1'b0;
            pressed_prev[k] = 1'b0;
            phase[k]        = PH_IDLE;
            countdown[k]    = '0;
            flags[k]        = '0;
         end
      endfunction

      function void write_reg(bit [CSR_IDX_W-1:0] idx, bit [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_SCAN_PERIOD:  scan_period  = data[SCAN_W-1:0];
            CSR_LONG_TICKS:   long_ticks   = data[TICKS_W-1:0];
            CSR_DOUBLE_TICKS: double_ticks = data[TICKS_W-1:0];
            CSR_REPEAT_TICKS: repeat_ticks = data[TICKS_W-1:0];
            CSR_ACTIVE_MASK:  active_mask  = data[MASK_W-1:0];
            default: ;
         endcase
      endfunction

      // one pin sample of one key: level, edges and press phase
      function void scan_key(int k, bit [3:0] pins);
         bit now;
         now = (pins[k] == active_mask[k]);
         pressed_prev[k] = pressed[k];
         pressed[k]      = now;
         flags[k][FLAG_HOLD] = now;
         if (now && !pressed_prev[k]) flags[k][FLAG_DOWN] = 1'b1;
         if (!now && pressed_prev[k]) flags[k][FLAG_UP] = 1'b1;
         case (phase[k])
            PH_PRESSED: begin
               if (!now) begin
                  countdown[k] = double_ticks;
                  phase[k]     = PH_WAIT_SECOND;
               end else if (countdown[k] == 0) begin
                  countdown[k]        = repeat_ticks;
                  flags[k][FLAG_LONG] = 1'b1;
                  phase[k]            = PH_LONG_HELD;
               end
            end
            PH_WAIT_SECOND: begin
               if (now) begin
                  flags[k][FLAG_DOUBLE] = 1'b1;
                  phase[k]              = PH_SECOND_HELD;
               end else if (countdown[k] == 0) begin
                  flags[k][FLAG_SINGLE] = 1'b1;
                  phase[k]              = PH_IDLE;
               end
            end
            PH_SECOND_HELD: begin
               if (!now) phase[k] = PH_IDLE;
            end
            PH_LONG_HELD: begin
               if (!now) begin
                  phase[k] = PH_IDLE;
               end else if (countdown[k] == 0) begin
                  countdown[k]          = repeat_ticks;
                  flags[k][FLAG_REPEAT] = 1'b1;
               end
            end
            default: begin
               phase[k] = PH_IDLE;
               if (now) begin
                  countdown[k] = long_ticks;
                  phase[k]     = PH_PRESSED;
               end
            end
         endcase
      endfunction

      // apply one accepted word and queue the hit it must give
      function void predict_word(bit kind, bit [3:0] pins, bit [1:0] key, bit [6:0] mask);
         bit              hit;
         bit [FLAG_W-1:0] clr;
         hit = 1'b0;
         if (kind == KIND_TICK) begin
            scan_count = scan_count + 1'b1;
            for (int k = 0; k < NUM_KEYS; k++)
               if (countdown[k] != 0) countdown[k] = countdown[k] - 1'b1;
            if (scan_count >= scan_period) begin
               scan_count = '0;
               for (int k = 0; k < NUM_KEYS; k++) scan_key(k, pins);
            end
         end else if ((flags[key] & mask) != 0) begin
            // hold follows the pins only, a check never clears it
            clr = mask;
            clr[FLAG_HOLD] = 1'b0;
            flags[key] = flags[key] & ~clr;
            hit = 1'b1;
         end
         expected_hits.push_back(hit);
      endfunction

      function check_status_type check_word(logic [7:0] got, output bit [7:0] want);
         want = '0;
         if (expected_hits.size() == 0) return CHK_UNEXPECTED;
         want[0] = expected_hits.pop_front();
         return (got === want) ? CHK_OK : CHK_MISMATCH;
      endfunction

      function int pending();
         return expected_hits.size();
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // signals and block under test
   // ------------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata = '0;   // pin_levels[3:0], key_index[5:4], event_mask[12:6]
   logic                  req_tuser = 1'b0; // kind
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;        // hit[0]
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   multi_key_click_event_detector dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   click_scoreboard  sb;
   int               errors = 0;
   int               burst_left = 0;
   bit               hold_off_req = 1'b0;

   // settings as last written, for shaping the key gestures
   bit [SCAN_W-1:0]  cur_scan;
   bit [TICKS_W-1:0] cur_long;
   bit [TICKS_W-1:0] cur_double;
   bit [TICKS_W-1:0] cur_repeat;
   bit [MASK_W-1:0]  cur_mask;

   // gesture state per key: pressed or not, and ticks left in that state
   bit               key_held[NUM_KEYS];
   int               key_left[NUM_KEYS];

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("multi_key_click_event_detector verification failed");
      $finish;
   end

   task automatic report(input string what);
      errors++;
      if (errors <= REPORT_CAP) $display("ERROR at %0t ns: %s", $time, what);
   endtask

   // ------------------------------------------------------------------------
   // register writes, only while the detector is idle
   // ------------------------------------------------------------------------
   task automatic csr_write(input bit [CSR_IDX_W-1:0] idx, input bit [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic apply_settings(input bit [15:0] sp, input bit [15:0] lt,
                                 input bit [15:0] dt, input bit [15:0] rt,
                                 input bit [15:0] am);
      csr_write(CSR_SCAN_PERIOD, sp);
      csr_write(CSR_LONG_TICKS, lt);
      csr_write(CSR_DOUBLE_TICKS, dt);
      csr_write(CSR_REPEAT_TICKS, rt);
      csr_write(CSR_ACTIVE_MASK, am);
      // a write to an unmapped index must change nothing
      csr_write(3'($urandom_range(CSR_UNUSED_FIRST, CSR_UNUSED_LAST)), 16'($urandom));
      csr_we <= 1'b0;
      @(posedge clock);
      cur_scan   = sp[SCAN_W-1:0];
      cur_long   = lt;
      cur_double = dt;
      cur_repeat = rt;
      cur_mask   = am[MASK_W-1:0];
   endtask

   // ------------------------------------------------------------------------
   // input side: bursts of words with random gaps
   // ------------------------------------------------------------------------
   task automatic send_word(input bit kind, input bit [3:0] pins, input bit [1:0] key,
                            input bit [6:0] mask);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                  : $urandom_range(1, 30);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {3'b000, mask, key, pins};
      do @(posedge clock); while (!req_tready);
      sb.predict_word(kind, pins, key, mask);
      burst_left--;
   endtask

   // wait for every expected word, then let the pipeline settle
   task automatic drain();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic bit [6:0] flag_bit(input int pos);
      return 7'(1) << pos;
   endfunction

   // ticks a key stays in its new state: taps, clicks near the double
   // window, and presses held past the long time
   function automatic int gesture_len(input bit pressing);
      int unit;
      unit = (cur_scan == 0) ? 1 : int'(cur_scan);
      case ($urandom_range(0, 3))
         0: return unit * $urandom_range(1, 3);
         1, 2: return $urandom_range(1, int'(cur_double) + 2 * unit);
         default: begin
            if (pressing && cur_long <= 400)
               return int'(cur_long) + $urandom_range(0, 3 * int'(cur_repeat) + 2 * unit);
            return $urandom_range(1, 3 * unit + int'(cur_double));
         end
      endcase
   endfunction

   task automatic run_random(input int count);
      bit [3:0] pins;
      bit [6:0] mask;
      int       pick;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            // check word: mostly one flag, sometimes all, none or any mix
            pick = $urandom_range(0, 19);
            if (pick < 10)      mask = flag_bit($urandom_range(FLAG_HOLD, FLAG_REPEAT));
            else if (pick < 15) mask = 7'($urandom);
            else if (pick < 18) mask = '1;
            else                mask = '0;
            send_word(KIND_CHECK, 4'($urandom), 2'($urandom), mask);
         end else begin
            for (int k = 0; k < NUM_KEYS; k++) begin
               if (key_left[k] <= 0) begin
                  key_held[k] = !key_held[k];
                  key_left[k] = gesture_len(key_held[k]);
               end
               key_left[k]--;
               pins[k] = key_held[k] ? cur_mask[k] : !cur_mask[k];
            end
            // now and then a glitch on the pins
            if ($urandom_range(0, 11) == 0) pins = pins ^ 4'($urandom);
            send_word(KIND_TICK, pins, 2'($urandom), 7'($urandom));
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // result side: stalls on changing patterns, one long hold-off on request
   // ------------------------------------------------------------------------
   initial begin : result_sink
      rx_mode_type      mode;
      int               mode_left;
      int               cyc;
      int               period;
      bit [7:0]         want;
      check_status_type status;
      mode      = RX_OPEN;
      mode_left = 0;
      cyc       = 0;
      period    = 3;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         cyc++;
         if (rsp_tvalid && rsp_tready) begin
            status = sb.check_word(rsp_tdata, want);
            if (status == CHK_UNEXPECTED)
               report($sformatf("result word 0x%02h with no word expected", rsp_tdata));
            else if (status == CHK_MISMATCH)
               report($sformatf("hit word 0x%02h, expected 0x%02h", rsp_tdata, want));
         end
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 200);
               period    = $urandom_range(2, 5);
            end
            mode_left--;
            case (mode)
               RX_OPEN:   rsp_tready <= 1'b1;
               RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
               default:   rsp_tready <= ((cyc % period) == 0);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin : main_seq
      bit [3:0] all_up;
      bit [3:0] all_down;
      bit [3:0] mid_down;
      sb = new();
      for (int k = 0; k < NUM_KEYS; k++) begin
         key_held[k] = 1'b0;
         key_left[k] = 0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // keys 0 and 2 active high, keys 1 and 3 active low, fast timers
      apply_settings(16'd1, 16'd3, 16'd2, 16'd2, 16'b0101);
      all_up   = 4'b1010;
      all_down = 4'b0101;
      mid_down = 4'b1100;   // keys 1 and 2 pressed

      // checks before anything happened
      send_word(KIND_CHECK, 4'h0, 2'd0, 7'h7f);
      send_word(KIND_CHECK, 4'hf, 2'd3, 7'h00);
      // all keys held through long and one repeat
      send_word(KIND_TICK, all_up, 2'd0, 7'h00);
      repeat (6) send_word(KIND_TICK, all_down, 2'd3, 7'h7f);
      // hold survives a check, the rest is cleared
      send_word(KIND_CHECK, 4'h0, 2'd0, flag_bit(FLAG_HOLD));
      send_word(KIND_CHECK, 4'h0, 2'd0, 7'h7f);
      send_word(KIND_CHECK, 4'h0, 2'd0, 7'h7f);
      send_word(KIND_TICK, all_up, 2'd0, 7'h00);
      send_word(KIND_CHECK, 4'h0, 2'd1, flag_bit(FLAG_UP));
      // double press on keys 1 and 2
      send_word(KIND_TICK, mid_down, 2'd0, 7'h00);
      send_word(KIND_TICK, all_up, 2'd0, 7'h00);
      send_word(KIND_TICK, mid_down, 2'd0, 7'h00);
      send_word(KIND_TICK, all_up, 2'd0, 7'h00);
      // single press: release and let the double window run out
      send_word(KIND_TICK, mid_down, 2'd0, 7'h00);
      repeat (3) send_word(KIND_TICK, all_up, 2'd0, 7'h00);
      send_word(KIND_CHECK, 4'h0, 2'd2, flag_bit(FLAG_SINGLE) | flag_bit(FLAG_DOUBLE));
      send_word(KIND_CHECK, 4'h0, 2'd1, flag_bit(FLAG_DOUBLE));
      send_word(KIND_CHECK, 4'h0, 2'd3, flag_bit(FLAG_REPEAT));
      drain();

      // shortest timers, all keys active low, junk in the upper write bits
      apply_settings({8'($urandom), 8'd1}, 16'd1, 16'd1, 16'd1, {12'($urandom), 4'd0});
      run_random(PHASE_WORDS);
      drain();

      // zero scan period: every tick scans
      apply_settings({8'($urandom), 8'd0}, 16'($urandom_range(2, 12)),
                     16'($urandom_range(1, 8)), 16'($urandom_range(1, 6)), 16'($urandom));
      run_random(PHASE_WORDS);
      drain();

      // values as after reset
      apply_settings(16'(RST_SCAN_PERIOD), RST_LONG_TICKS, RST_DOUBLE_TICKS,
                     RST_REPEAT_TICKS, 16'(RST_ACTIVE_MASK));
      run_random(PHASE_WORDS);
      drain();

      // longest settings
      apply_settings(16'd255, 16'hffff, 16'hffff, 16'hffff, 16'hf);
      run_random(PHASE_WORDS);
      drain();

      // moderate timers, with one long hold-off on the result side
      apply_settings(16'($urandom_range(1, 4)), 16'($urandom_range(2, 30)),
                     16'($urandom_range(1, 10)), 16'($urandom_range(1, 8)), 16'($urandom));
      hold_off_req = 1'b1;
      run_random(PHASE_WORDS);
      drain();

      apply_settings(16'($urandom_range(1, 3)), 16'($urandom_range(2, 20)),
                     16'($urandom_range(1, 6)), 16'($urandom_range(1, 5)), 16'($urandom));
      run_random(PHASE_WORDS);
      drain();

      if (sb.pending() != 0)
         report($sformatf("%0d expected result words never arrived", sb.pending()));
      if (errors == 0) begin
         $display("multi_key_click_event_detector verification clean");
      end else begin
         $display("multi_key_click_event_detector verification failed");
      end
      $finish;
   end

endmodule
